/* design/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and the transliteration table of the UTF-8 to
// ASCII transliterator.
// ----------------------------------------------------------------------------
`default_nettype none

package u2a_pkg;

  // Register map: word index of each configuration register.
  localparam int unsigned RegAddrWidth = 3;
  localparam logic [0:0] REG_OUT_CAPACITY = 1'b0;
  localparam logic [15:0] OutCapacityReset = 16'd256;

  // Depth of the job queue between the decoder and the output stage.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  // Characters used by the table and the fallback.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_QMARK = 8'h3f;

  // One decoded byte's worth of output: up to three characters, in order
  // from text[0], or the terminator.
  typedef struct packed {
    logic term;
    logic [1:0] count;
    logic [2:0][7:0] text;
  } u2a_job_t;

  // Result of a table lookup: replacement text and its length.
  typedef struct packed {
    logic [1:0] len;
    logic [2:0][7:0] text;
  } u2a_xlat_t;

  // Replacement string of a completed code point.
  function automatic u2a_xlat_t xlat_code(input logic [20:0] code);
    u2a_xlat_t r;
    r.len = 2'd1;
    r.text = {CH_NUL, CH_NUL, CH_QMARK};
    case (code)
      21'h0000a9: begin
        r.len = 2'd3;
        r.text = {8'h29, 8'h63, 8'h28};  // "(c)"
      end
      21'h0000d7: r.text = {CH_NUL, CH_NUL, 8'h78};  // "x"
      21'h002013: r.text = {CH_NUL, CH_NUL, 8'h2d};  // "-"
      21'h002018: r.text = {CH_NUL, CH_NUL, 8'h27};  // "'"
      21'h002019: r.text = {CH_NUL, CH_NUL, 8'h27};
      21'h00201c: r.text = {CH_NUL, CH_NUL, 8'h22};  // double quote
      21'h00201d: r.text = {CH_NUL, CH_NUL, 8'h22};
      21'h002192: begin
        r.len = 2'd2;
        r.text = {CH_NUL, 8'h3e, 8'h2d};  // "->"
      end
      21'h00feff: begin
        r.len = 2'd0;
        r.text = {CH_NUL, CH_NUL, CH_NUL};
      end
      default: r.len = 2'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/u2a_front.sv */
// ----------------------------------------------------------------------------
// u2a_front
// Decodes input bytes, assembles code points, applies the buffer limit and
// produces one job per byte that has any output.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic [7:0] in_byte,
  input  wire logic [15:0] out_capacity,
  output u2a_pkg::u2a_job_t job,
  output logic job_valid
);
  import u2a_pkg::*;

  logic [15:0] out_count;
  logic [15:0] out_count_next;
  logic [20:0] pending_code;
  logic [20:0] pending_code_next;
  logic [1:0] bytes_needed;
  logic [1:0] bytes_needed_next;

  logic [20:0] shifted_code;
  u2a_xlat_t xlat;
  u2a_xlat_t cand;
  logic cand_valid;
  logic [17:0] count_ext;
  logic [17:0] cap_ext;
  logic [1:0] allowed;
  logic [1:0] emit_n;

  assign shifted_code = {pending_code[14:0], in_byte[5:0]};
  assign xlat = xlat_code(shifted_code);

  // Number of characters that still fit, at most three.
  assign count_ext = {2'b00, out_count};
  assign cap_ext = {2'b00, out_capacity};
  always_comb begin
    if (count_ext + 18'd4 <= cap_ext) begin
      allowed = 2'd3;
    end else if (count_ext + 18'd3 <= cap_ext) begin
      allowed = 2'd2;
    end else if (count_ext + 18'd2 <= cap_ext) begin
      allowed = 2'd1;
    end else begin
      allowed = 2'd0;
    end
  end

  // Byte classification and sequence assembly.
  always_comb begin
    pending_code_next = pending_code;
    bytes_needed_next = bytes_needed;
    cand.len = 2'd0;
    cand.text = {CH_NUL, CH_NUL, CH_NUL};
    cand_valid = 1'b0;
    if (in_byte == 8'h00) begin
      pending_code_next = '0;
      bytes_needed_next = 2'd0;
    end else if (in_byte[7] == 1'b0) begin
      cand.len = 2'd1;
      cand.text = {CH_NUL, CH_NUL, in_byte};
      cand_valid = 1'b1;
      bytes_needed_next = 2'd0;
    end else if (in_byte[7:6] == 2'b10) begin
      if (bytes_needed != 2'd0) begin
        pending_code_next = shifted_code;
        bytes_needed_next = bytes_needed - 2'd1;
        if (bytes_needed == 2'd1) begin
          cand = xlat;
          cand_valid = 1'b1;
        end
      end
    end else if (in_byte[7:5] == 3'b110) begin
      pending_code_next = {16'd0, in_byte[4:0]};
      bytes_needed_next = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      pending_code_next = {17'd0, in_byte[3:0]};
      bytes_needed_next = 2'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      pending_code_next = {18'd0, in_byte[2:0]};
      bytes_needed_next = 2'd3;
    end
  end

  // Job assembly with the buffer limit applied.
  always_comb begin
    emit_n = (cand.len < allowed) ? cand.len : allowed;
    if (!cand_valid) begin
      emit_n = 2'd0;
    end
    job.term = (in_byte == 8'h00);
    job.text = cand.text;
    job.count = emit_n;
    out_count_next = out_count + {14'd0, emit_n};
    if (in_byte == 8'h00) begin
      job.count = 2'd1;
      job.text = {CH_NUL, CH_NUL, CH_NUL};
      out_count_next = '0;
    end
    job_valid = in_fire && (job.count != 2'd0);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= '0;
      pending_code <= '0;
      bytes_needed <= 2'd0;
    end else if (in_fire) begin
      out_count <= out_count_next;
      pending_code <= pending_code_next;
      bytes_needed <= bytes_needed_next;
    end
  end

endmodule

`default_nettype wire

/* design/u2a_queue.sv */
// ----------------------------------------------------------------------------
// u2a_queue
// Short job queue between the decoder and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire u2a_pkg::u2a_job_t push_job,
  input  wire logic pop,
  output u2a_pkg::u2a_job_t head,
  output logic empty,
  output logic full
);
  import u2a_pkg::*;

  u2a_job_t slots [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr;
  logic [QueuePtrWidth-1:0] rd_ptr;
  logic [QueuePtrWidth:0] fill;

  assign empty = (fill == '0);
  assign full = (fill == (QueuePtrWidth+1)'(QueueDepth));
  assign head = slots[rd_ptr];

  // Storage is written without reset; only pointers and the fill count are cleared.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from an empty queue");
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= (QueuePtrWidth+1)'(QueueDepth))
    else $error("queue fill beyond depth");

endmodule

`default_nettype wire

/* design/u2a_back.sv */
// ----------------------------------------------------------------------------
// u2a_back
// Output stage: walks the characters of the head job into the output
// register, one word per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module u2a_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire u2a_pkg::u2a_job_t head,
  input  wire logic empty,
  output logic pop,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [7:0] m_tdata,
  output logic m_tuser,
  output logic m_tlast
);
  import u2a_pkg::*;

  logic [1:0] idx;
  logic load;
  logic at_last;

  assign load = !empty && (!m_tvalid || m_tready);
  assign at_last = (idx == head.count - 2'd1);
  assign pop = load && at_last;

  // Character index within the head job, and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= head.text[idx];
      m_tuser <= head.term;
      m_tlast <= at_last;
    end
  end

  a_idx_in_job : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (idx < head.count))
    else $error("character index past the end of the job");
  a_term_is_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("terminator word not marked last");
  a_term_is_nul : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == CH_NUL))
    else $error("terminator word carries a character");

endmodule

`default_nettype wire

/* design/utf8_to_ascii_transliterator.sv */
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator
// Streams UTF-8 bytes in and transliterated ASCII characters out.
// ----------------------------------------------------------------------------
// Each input byte gives zero to three output words; a zero byte gives the
// terminator word (tuser high) and resets the string state. The decoder
// takes a new byte every cycle while its four-entry job queue has room;
// the output stage delivers one word per cycle while m_tready is high, so
// a byte that expands into three characters holds the output for one word
// per character and the queue absorbs the difference. At most out_capacity
// minus one characters per string are emitted and later ones are dropped;
// the terminator never is.
// The capacity register (byte address 0, reset 256) may only be written
// while no string bytes are in flight.
`default_nettype none

module utf8_to_ascii_transliterator (
  input  wire logic clk,
  input  wire logic rst,
  // Input stream.
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [7:0] s_tdata,  // [7:0] in_byte
  // Output stream.
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [7:0] m_tdata,  // [7:0] out_char
  output logic m_tuser,  // [0] is_terminator
  output logic m_tlast,  // last word caused by one input byte
  // Configuration port.
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [u2a_pkg::RegAddrWidth-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import u2a_pkg::*;

  logic [15:0] out_capacity;
  logic in_fire;
  u2a_job_t job;
  logic job_valid;
  u2a_job_t head;
  logic q_empty;
  logic q_full;
  logic q_pop;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= OutCapacityReset;
    end else if (psel && penable && pwrite && pready
                 && paddr[RegAddrWidth-1] == REG_OUT_CAPACITY) begin
      out_capacity <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[RegAddrWidth-1] == REG_OUT_CAPACITY) ?
                  {16'd0, out_capacity} : 32'd0;

  // Input handshake.
  assign s_tready = !q_full;
  assign in_fire = s_tvalid && s_tready;

  u2a_front u_front (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .in_byte(s_tdata),
    .out_capacity(out_capacity),
    .job(job),
    .job_valid(job_valid)
  );

  u2a_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(job_valid),
    .push_job(job),
    .pop(q_pop),
    .head(head),
    .empty(q_empty),
    .full(q_full)
  );

  u2a_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .empty(q_empty),
    .pop(q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule

`default_nettype wire

/* verif/utf8_to_ascii_transliterator_test.sv */
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator_test
// Self-checking testbench of the UTF-8 to ASCII transliterator.
// ----------------------------------------------------------------------------
// A queue of UTF-8 bytes feeds a clocked stream driver. Every accepted byte
// goes through a transliteration predictor that keeps its own string state
// and capacity, and the characters it predicts wait in a queue. A clocked
// monitor takes each output word and compares it with the oldest predicted
// character. Both sides idle at random. The capacity register is reprogrammed
// between phases, once the block has drained: its largest value, small
// values that truncate strings, and random values. One phase holds the output
// off for a long stretch so that the block backs up and stalls its input.
`timescale 1ns / 100ps

module utf8_to_ascii_transliterator_test;

  localparam int unsigned HoldCycles = 150;
  localparam int unsigned DrainCycles = 16;
  localparam logic [u2a_pkg::RegAddrWidth-1:0] CapacityAddr =
    (u2a_pkg::RegAddrWidth)'(4 * u2a_pkg::REG_OUT_CAPACITY);

  // One predicted output word.
  typedef struct {
    logic [7:0] ch;
    logic term;
    logic last;
  } char_word_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;  // [7:0] in_byte
  logic m_tvalid;
  logic m_tready;
  logic [7:0] m_tdata;  // [7:0] out_char
  logic m_tuser;  // [0] is_terminator
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [u2a_pkg::RegAddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Stimulus and scoreboard storage.
  logic [7:0] utf8_bytes[$];
  char_word_t pending_chars[$];
  int unsigned bytes_pushed = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatch_count = 0;

  // Predictor state: its own copy of the capacity and the string state.
  logic [15:0] line_capacity = u2a_pkg::OutCapacityReset;
  logic [15:0] chars_written = '0;
  logic [20:0] code_acc = '0;
  logic [1:0] cont_left = '0;

  // Idling control.
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_hold_left = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_taken = 0;

  utf8_to_ascii_transliterator u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(input logic enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // A character is kept only while two places remain in the buffer.
  function automatic void put_char(input logic [7:0] ch);
    if (int'(chars_written) + 2 > int'(line_capacity)) return;
    pending_chars.push_back(char_word_t'{ch, 1'b0, 1'b0});
    chars_written = chars_written + 16'd1;
  endfunction

  // Replacement text of a completed code point.
  function automatic void put_code(input logic [20:0] cp);
    case (cp)
      21'h0000a9: begin
        put_char("(");
        put_char("c");
        put_char(")");
      end
      21'h0000d7: put_char("x");
      21'h002013: put_char("-");
      21'h002018, 21'h002019: put_char("'");
      21'h00201c, 21'h00201d: put_char(8'h22);
      21'h002192: begin
        put_char("-");
        put_char(">");
      end
      21'h00feff: ;
      default: put_char("?");
    endcase
  endfunction

  // Predicts the words one accepted input byte causes.
  function automatic void transliterate_byte(input logic [7:0] b);
    int first;
    first = pending_chars.size();
    if (b == 8'h00) begin
      pending_chars.push_back(char_word_t'{8'h00, 1'b1, 1'b0});
      chars_written = '0;
      code_acc = '0;
      cont_left = '0;
    end else if (b < 8'h80) begin
      put_char(b);
      cont_left = '0;
    end else if (b < 8'hc0) begin
      if (cont_left != 0) begin
        code_acc = {code_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 0) put_code(code_acc);
      end
    end else if (b < 8'he0) begin
      code_acc = 21'(b[4:0]);
      cont_left = 2'd1;
    end else if (b < 8'hf0) begin
      code_acc = 21'(b[3:0]);
      cont_left = 2'd2;
    end else if (b < 8'hf8) begin
      code_acc = 21'(b[2:0]);
      cont_left = 2'd3;
    end
    if (pending_chars.size() > first) pending_chars[pending_chars.size() - 1].last = 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 30) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Compares one output word with the oldest predicted character.
  task automatic check_word();
    char_word_t w;
    if (pending_chars.size() == 0) begin
      flag_mismatch($sformatf("unexpected word %h tuser %b tlast %b",
                              m_tdata, m_tuser, m_tlast));
      return;
    end
    w = pending_chars.pop_front();
    if (m_tdata !== w.ch)
      flag_mismatch($sformatf("out_char %h, predicted %h", m_tdata, w.ch));
    if (m_tuser !== w.term)
      flag_mismatch($sformatf("is_terminator %b, predicted %b", m_tuser, w.term));
    if (m_tlast !== w.last)
      flag_mismatch($sformatf("last_of_run %b, predicted %b", m_tlast, w.last));
  endtask

  // Input driver: a word stays up until taken, then an optional gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        transliterate_byte(s_tdata);
        bytes_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (utf8_bytes.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= utf8_bytes.pop_front();
          tx_gap = pick_gap(tx_idle_on);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each taken word and stalls at random or on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
      rx_hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) check_word();
      if (hold_taken != hold_asks) begin
        hold_taken = hold_asks;
        rx_hold_left = HoldCycles;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_gap = pick_gap(rx_idle_on);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    utf8_bytes.push_back(b);
    bytes_pushed++;
  endtask

  // Encodes a code point in the given number of bytes, overlong forms included.
  task automatic push_code(input logic [20:0] cp, input int unsigned nbytes);
    case (nbytes)
      2: begin
        push_byte({3'b110, cp[10:6]});
        push_byte({2'b10, cp[5:0]});
      end
      3: begin
        push_byte({4'b1110, cp[15:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
      default: begin
        push_byte({5'b11110, cp[20:18]});
        push_byte({2'b10, cp[17:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [20:0] mapped_code(input int unsigned idx);
    case (idx)
      0: return 21'h0000a9;
      1: return 21'h0000d7;
      2: return 21'h002013;
      3: return 21'h002018;
      4: return 21'h002019;
      5: return 21'h00201c;
      6: return 21'h00201d;
      7: return 21'h002192;
      default: return 21'h00feff;
    endcase
  endfunction

  // One random character: mostly well-formed text, some noise.
  task automatic push_random_char();
    int unsigned r;
    int unsigned n;
    logic [20:0] cp;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      push_byte(8'($urandom_range(1, 127)));
    end else if (r < 60) begin
      cp = mapped_code($urandom_range(0, 8));
      push_code(cp, (cp < 21'h800) ? 2 : 3);
    end else if (r < 72) begin
      n = $urandom_range(2, 4);
      case (n)
        2: cp = 21'($urandom_range(21'h80, 21'h7ff));
        3: cp = 21'($urandom_range(21'h800, 21'hffff));
        default: cp = 21'($urandom_range(21'h10000, 21'h1fffff));
      endcase
      push_code(cp, n);
    end else if (r < 78) begin
      push_code(21'($urandom_range(0, 127)), $urandom_range(2, 4));
    end else if (r < 84) begin
      push_byte(8'h00);
    end else begin
      case ($urandom_range(0, 3))
        0: push_byte(8'($urandom_range(8'h80, 8'hbf)));
        1: push_byte(8'($urandom_range(8'hf8, 8'hff)));
        2: push_byte(8'($urandom_range(8'hc0, 8'hf7)));
        default: begin
          push_byte(8'($urandom_range(8'he0, 8'hf7)));
          push_byte(8'($urandom_range(8'h80, 8'hbf)));
        end
      endcase
    end
  endtask

  // Text with a three- and a two-character replacement, for truncation.
  task automatic push_probe();
    logic [7:0] seq[$];
    seq = '{8'h41, 8'hc2, 8'ha9, 8'h42, 8'he2, 8'h86, 8'h92, 8'h43, 8'h00};
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  // Waits until every byte is taken and every predicted word has come,
  // then lets the block settle on bytes that cause no word.
  task automatic drain();
    while (bytes_accepted != bytes_pushed) @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Reads the capacity register back and checks it against the model copy.
  task automatic read_capacity();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CapacityAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, line_capacity})
      flag_mismatch($sformatf("capacity reads %h, expected %h", prdata, line_capacity));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_capacity(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CapacityAddr;
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    line_capacity = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_capacity();
  endtask

  // Random phase of a given length under a given capacity.
  task automatic random_phase(input logic [15:0] cap, input int unsigned nbytes);
    int unsigned target;
    write_capacity(cap);
    target = bytes_pushed + nbytes;
    while (bytes_pushed < target) push_random_char();
    drain();
  endtask

  initial begin : stimulus
    logic [7:0] seq[$];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    read_capacity();

    // Directed: ASCII extremes, table entries, BOM, noise bytes, the largest
    // code point, an overlong NUL, interrupted sequences and the terminator.
    seq = '{8'h01, 8'h7f, 8'hc2, 8'ha9, 8'he2, 8'h86, 8'h92, 8'hef, 8'hbb, 8'hbf,
            8'h80, 8'hff, 8'hf8, 8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'hc0, 8'h80,
            8'he2, 8'h41, 8'he2, 8'hc3, 8'h97, 8'h00};
    foreach (seq[i]) push_byte(seq[i]);
    drain();

    // Small capacities cut strings short, down to the terminator alone.
    for (int c = 1; c <= 6; c++) begin
      write_capacity(16'(c));
      push_probe();
      drain();
    end
    write_capacity(16'hffff);
    push_probe();
    drain();

    // Random text under several capacities.
    random_phase(16'hffff, 40);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(16'($urandom_range(2, 12)), 40);
    rx_idle_on = 1'b1;
    @(posedge clk);
    hold_asks <= hold_asks + 1;
    random_phase(16'($urandom_range(13, 300)), 40);
    tx_idle_on = 1'b1;
    write_capacity(16'($urandom_range(1, 40)));
    while (bytes_pushed < 280) push_random_char();
    push_byte(8'h00);
    drain();

    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("utf8_to_ascii_transliterator regression: pass");
    end else begin
      $display("utf8_to_ascii_transliterator regression: fail");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("utf8_to_ascii_transliterator regression: fail");
    $finish;
  end

endmodule

/* sim.f */
design/u2a_pkg.sv
design/u2a_front.sv
design/u2a_queue.sv
design/u2a_back.sv
design/utf8_to_ascii_transliterator.sv
verif/utf8_to_ascii_transliterator_test.sv
